[hdl/ars_pkg.sv]
// ----------------------------------------------------------------------------
// ars_pkg - shared types and constants for the additive resize core
// Field widths, configuration register indexes and the 24-bit saturating
// adder used by the block-sum datapath.
// ----------------------------------------------------------------------------
package ars_pkg;

  // Field widths
  localparam int PIX_W   = 16;  // Q2.13 input pixel
  localparam int SUM_W   = 24;  // Q10.13 sums and results
  localparam int POS_W   = 12;  // row / column positions
  localparam int DIM_W   = 13;  // size registers
  localparam int SCALE_W = 5;   // scale registers
  localparam int CFG_W   = 13;  // widest configuration register
  localparam int IDX_W   = 3;   // configuration index

  // Largest size a dimension register may take
  localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'(4096);

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_MODE       = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_IN_WIDTH   = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_IN_HEIGHT  = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_OUT_WIDTH  = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_OUT_HEIGHT = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_X_SCALE    = IDX_W'(5);
  localparam logic [IDX_W-1:0] REG_Y_SCALE    = IDX_W'(6);

  // Saturating 24-bit signed add
  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0] a,
    input logic signed [SUM_W-1:0] b
  );
    logic signed [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add = s[SUM_W-1:0];
    end
  endfunction

  // Size register as used: zero acts as one, above the limit acts as the limit
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (v == '0) begin
      clamp_dim = DIM_W'(1);
    end else if (v > DIM_LIMIT) begin
      clamp_dim = DIM_LIMIT;
    end else begin
      clamp_dim = v;
    end
  endfunction

endpackage

[hdl/ars_ram.sv]
// ----------------------------------------------------------------------------
// ars_ram - generic simple dual-port RAM
// One write port and one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module ars_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/additive_resize_core.sv]
// ----------------------------------------------------------------------------
// additive_resize_core - integer-ratio resize of one pixel channel
// Zero-insertion upsample or saturating block-sum downsample of a raster
// stream of Q2.13 pixels, with a line store of per-column partial sums.
// ----------------------------------------------------------------------------
// The core takes one pixel per clock and keeps that rate indefinitely while
// the sink keeps up. A pixel passes a capture stage, where the raster counters
// and the target/range decisions are evaluated and the line store is read,
// then a sum stage, where the running row sum and the column partial are
// added and the line store is written back; its result is then registered in
// the output register. The line store is a MAX_LINE x 24 RAM with one write
// and one registered read per cycle; a write-back that meets a read of the
// same column is forwarded. The line store needs no clearing after reset:
// every block row starts from zero. Configuration must be written only while
// no pixel is in flight; the core itself does not enforce this.
module additive_resize_core #(
  parameter int MAX_LINE  = 4096,
  parameter int MAX_SCALE = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_write,
  input  logic [ars_pkg::IDX_W-1:0]   cfg_index,
  input  logic [ars_pkg::CFG_W-1:0]   cfg_data,
  // pixel input
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [15:0]                 s_axis_tdata,   // [15:0] pixel_value
  // result output
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [47:0]                 m_axis_tdata,   // [11:0] target_row,
                                                      // [23:12] target_col,
                                                      // [47:24] result_value
  output logic                        m_axis_tlast    // frame_done
);

  localparam int AW = $clog2(MAX_LINE);
  localparam int SW = $clog2(MAX_SCALE);
  localparam int CW = (SW > ars_pkg::SCALE_W) ? SW : ars_pkg::SCALE_W;
  localparam int PW = ars_pkg::POS_W;
  localparam int DW = ars_pkg::DIM_W;
  localparam int MW = ars_pkg::DIM_W + ars_pkg::SCALE_W;  // product width

  // Sum-stage item
  typedef struct packed {
    logic                              mode_ds;
    logic                              emit;       // produces a result
    logic                              acc;        // updates the row sum
    logic                              wb;         // writes a column partial
    logic                              first_col;
    logic                              first_row;
    logic                              fwd;        // take partial from bypass
    logic [AW-1:0]                     addr;
    logic [PW-1:0]                     row;
    logic [PW-1:0]                     col;
    logic                              done;
    logic signed [ars_pkg::PIX_W-1:0]  pixel;
  } stage_t;

  // Configuration registers
  logic                           mode_downsample;
  logic [DW-1:0]                  in_width;
  logic [DW-1:0]                  in_height;
  logic [DW-1:0]                  out_width;
  logic [DW-1:0]                  out_height;
  logic [ars_pkg::SCALE_W-1:0]    x_scale;
  logic [ars_pkg::SCALE_W-1:0]    y_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_downsample <= 1'b0;
      in_width        <= DW'(1);
      in_height       <= DW'(1);
      out_width       <= DW'(1);
      out_height      <= DW'(1);
      x_scale         <= ars_pkg::SCALE_W'(1);
      y_scale         <= ars_pkg::SCALE_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        ars_pkg::REG_MODE:       mode_downsample <= cfg_data[0];
        ars_pkg::REG_IN_WIDTH:   in_width        <= cfg_data;
        ars_pkg::REG_IN_HEIGHT:  in_height       <= cfg_data;
        ars_pkg::REG_OUT_WIDTH:  out_width       <= cfg_data;
        ars_pkg::REG_OUT_HEIGHT: out_height      <= cfg_data;
        ars_pkg::REG_X_SCALE:    x_scale         <= cfg_data[ars_pkg::SCALE_W-1:0];
        ars_pkg::REG_Y_SCALE:    y_scale         <= cfg_data[ars_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective sizes and scales
  logic [DW-1:0]               iw, ih, ow, oh;
  logic [ars_pkg::SCALE_W-1:0] xs, ys;

  always_comb begin
    iw = ars_pkg::clamp_dim(in_width);
    ih = ars_pkg::clamp_dim(in_height);
    ow = ars_pkg::clamp_dim(out_width);
    oh = ars_pkg::clamp_dim(out_height);
    if (x_scale == '0) begin
      xs = ars_pkg::SCALE_W'(1);
    end else if (32'(x_scale) > MAX_SCALE) begin
      xs = ars_pkg::SCALE_W'(MAX_SCALE);
    end else begin
      xs = x_scale;
    end
    if (y_scale == '0) begin
      ys = ars_pkg::SCALE_W'(1);
    end else if (32'(y_scale) > MAX_SCALE) begin
      ys = ars_pkg::SCALE_W'(MAX_SCALE);
    end else begin
      ys = y_scale;
    end
  end

  // Raster counters
  logic [PW-1:0] src_row, src_col, block_row, block_col;
  logic [SW-1:0] sub_row, sub_col;

  logic          in_acc;
  logic          last_col, last_row, sub_col_end, sub_row_end;

  assign in_acc      = s_axis_tvalid && s_axis_tready;
  assign last_col    = DW'(src_col) >= iw - DW'(1);
  assign last_row    = DW'(src_row) >= ih - DW'(1);
  assign sub_col_end = CW'(sub_col) >= CW'(xs - ars_pkg::SCALE_W'(1));
  assign sub_row_end = CW'(sub_row) >= CW'(ys - ars_pkg::SCALE_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      src_row   <= '0;
      src_col   <= '0;
      sub_row   <= '0;
      sub_col   <= '0;
      block_row <= '0;
      block_col <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        src_col   <= '0;
        sub_col   <= '0;
        block_col <= '0;
        if (last_row) begin
          src_row   <= '0;
          sub_row   <= '0;
          block_row <= '0;
        end else begin
          src_row <= src_row + PW'(1);
          if (sub_row_end) begin
            sub_row   <= '0;
            block_row <= block_row + PW'(1);
          end else begin
            sub_row <= sub_row + SW'(1);
          end
        end
      end else begin
        src_col <= src_col + PW'(1);
        if (sub_col_end) begin
          sub_col   <= '0;
          block_col <= block_col + PW'(1);
        end else begin
          sub_col <= sub_col + SW'(1);
        end
      end
    end
  end

  // Capture-stage decisions
  logic [MW-1:0] tr, tc, tr_next, tc_next, br_next, bc_next;
  logic          up_hit, up_done, ds_in, ds_done, hdone, vdone;
  logic [AW-1:0] rd_addr;

  always_comb begin
    tr      = MW'(src_row) * MW'(ys);
    tc      = MW'(src_col) * MW'(xs);
    tr_next = (MW'(src_row) + MW'(1)) * MW'(ys);
    tc_next = (MW'(src_col) + MW'(1)) * MW'(xs);
    br_next = (MW'(block_row) + MW'(1)) * MW'(ys);
    bc_next = (MW'(block_col) + MW'(1)) * MW'(xs);
    // upsample: target inside the output, last target inside the output
    up_hit  = (tr < MW'(oh)) && (tc < MW'(ow));
    up_done = (last_row || tr_next >= MW'(oh)) && (last_col || tc_next >= MW'(ow));
    // downsample: block inside the output, last block inside the output
    ds_in   = (DW'(block_row) < oh) && (DW'(block_col) < ow) && (32'(block_col) < MAX_LINE);
    ds_done = (DW'(block_row) >= oh - DW'(1) || br_next >= MW'(ih)) &&
              (DW'(block_col) >= ow - DW'(1) || bc_next >= MW'(iw));
    hdone   = sub_col_end || last_col;
    vdone   = sub_row_end || last_row;
    rd_addr = AW'(block_col);
  end

  // Sum stage
  stage_t                             s1;
  logic                               s1_valid;
  logic                               slot_free, s1_fire;
  logic signed [ars_pkg::SUM_W-1:0]   row_partial;
  logic signed [ars_pkg::SUM_W-1:0]   fwd_data;
  logic signed [ars_pkg::SUM_W-1:0]   ram_rdata;
  logic signed [ars_pkg::SUM_W-1:0]   p24, rp_base, rp, cp, tot;
  logic                               ram_we;

  assign slot_free     = !m_axis_tvalid || m_axis_tready;
  assign s1_fire       = s1_valid && slot_free;
  assign s_axis_tready = !s1_valid || slot_free;
  assign ram_we        = s1_fire && s1.wb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1.mode_ds   <= mode_downsample;
      s1.emit      <= mode_downsample ? (ds_in && hdone && vdone) : up_hit;
      s1.acc       <= mode_downsample && ds_in;
      s1.wb        <= mode_downsample && ds_in && hdone && !vdone;
      s1.first_col <= (sub_col == '0);
      s1.first_row <= (sub_row == '0);
      s1.fwd       <= ram_we && (s1.addr == rd_addr);
      s1.addr      <= rd_addr;
      s1.row       <= mode_downsample ? block_row : tr[PW-1:0];
      s1.col       <= mode_downsample ? block_col : tc[PW-1:0];
      s1.done      <= mode_downsample ? ds_done : up_done;
      s1.pixel     <= s_axis_tdata;
    end
  end

  // Column partial sums
  ars_ram #(
    .WIDTH (ars_pkg::SUM_W),
    .DEPTH (MAX_LINE)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1.addr),
    .wdata (tot),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Row running sum, then column total
  always_comb begin
    p24     = ars_pkg::SUM_W'($signed(s1.pixel));
    rp_base = s1.first_col ? '0 : row_partial;
    rp      = ars_pkg::sat_add(rp_base, p24);
    cp      = s1.first_row ? '0 : (s1.fwd ? fwd_data : ram_rdata);
    tot     = ars_pkg::sat_add(cp, rp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_partial <= '0;
    end else if (s1_fire && s1.acc) begin
      row_partial <= rp;
    end
  end

  // Bypass copy of the last write-back
  always_ff @(posedge clk) begin
    if (ram_we) begin
      fwd_data <= tot;
    end
  end

  // Output register
  logic [PW-1:0]                     out_row, out_col;
  logic signed [ars_pkg::SUM_W-1:0]  out_value;
  logic                              out_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_fire && s1.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1.emit) begin
      out_row   <= s1.row;
      out_col   <= s1.col;
      out_value <= s1.mode_ds ? tot : p24;
      out_done  <= s1.done;
    end
  end

  assign m_axis_tdata = {out_value, out_col, out_row};
  assign m_axis_tlast = out_done;

  // Checks
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> s1_valid)
    else $error("input stalled with an empty sum stage");

  a_stalled_item_kept: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !slot_free |=> s1_valid)
    else $error("sum stage item lost while stalled");

  a_writeback_downsample: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> s1.mode_ds)
    else $error("line store written in upsample mode");

  a_bypass_taken: assert property (@(posedge clk) disable iff (rst)
    in_acc && ram_we && (s1.addr == rd_addr) |=> s1.fwd)
    else $error("colliding write-back not forwarded");

endmodule

[tb/sv/tb_additive_resize_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_additive_resize_core - self-checking bench for the additive resize core
// A directed table (reset defaults, pixel extremes, ragged blocks, dropped
// targets, clamped registers) is followed by random frames in both modes,
// mid-frame reconfiguration in upsample mode and two large-target frames.
// Each result is checked against its table row or an in-bench resize predictor.
// ----------------------------------------------------------------------------
module tb_additive_resize_core;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 950;
  localparam int LINE_DEPTH   = 4096;

  // one output pixel write
  typedef struct packed {
    logic [11:0] row;
    logic [11:0] col;
    logic [23:0] sum;
    logic        last;
  } out_pixel_t;

  // one row of the directed table: a register write or a pixel
  typedef struct {
    bit                        is_cfg;
    logic [ars_pkg::IDX_W-1:0] idx;
    logic [15:0]               val;
    bit                        known;
    out_pixel_t                want;
  } dir_step_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [ars_pkg::IDX_W-1:0] cfg_index = '0;
  logic [ars_pkg::CFG_W-1:0] cfg_data = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [15:0]               s_axis_tdata = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [47:0]               m_axis_tdata;
  logic                      m_axis_tlast;

  // expectation typed into the table, travels with the pixel transaction
  bit               pix_known = 1'b0;
  out_pixel_t       pix_want = '0;

  out_pixel_t       pending_writes[$];
  dir_step_t        directed_steps[$];
  int               fault_count = 0;
  int               cycle_count = 0;
  int               random_sent = 0;
  bit               calm = 1'b0;

  // predictor copy of the registers
  logic [12:0] set_mode = 13'd0;
  logic [12:0] set_in_w = 13'd1, set_in_h = 13'd1;
  logic [12:0] set_out_w = 13'd1, set_out_h = 13'd1;
  logic [12:0] set_xs = 13'd1, set_ys = 13'd1;

  // predictor raster and block state
  int unsigned pix_row = 0, pix_col = 0;
  int unsigned in_blk_row = 0, in_blk_col = 0;
  int unsigned tgt_blk_row = 0, tgt_blk_col = 0;
  int          run_sum = 0;
  int          col_sum[LINE_DEPTH];

  additive_resize_core uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic int unsigned eff_size(input int unsigned v);
    if (v == 0) return 1;
    if (v > 4096) return 4096;
    return v;
  endfunction

  function automatic int unsigned eff_ratio(input int unsigned v);
    if (v == 0) return 1;
    if (v > 16) return 16;
    return v;
  endfunction

  function automatic int clip24(input int x);
    if (x > 8388607) return 8388607;
    if (x < -8388608) return -8388608;
    return x;
  endfunction

  function automatic int unsigned lesser(input int unsigned a, input int unsigned b);
    return (a < b) ? a : b;
  endfunction

  // advance the predictor by one pixel; returns 1 when an output write is due
  function automatic bit resize_step(input logic [15:0] raw, output out_pixel_t o);
    int          p;
    int          part;
    int          total;
    int unsigned iw, ih, ow, oh, xs, ys, tr, tc, span_r, span_c;
    bit          row_end, frame_end, h_close, v_close, got;
    p = int'($signed(raw));
    iw = eff_size(set_in_w);
    ih = eff_size(set_in_h);
    ow = eff_size(set_out_w);
    oh = eff_size(set_out_h);
    xs = eff_ratio(set_xs[4:0]);
    ys = eff_ratio(set_ys[4:0]);
    row_end = pix_col >= iw - 1;
    frame_end = pix_row >= ih - 1;
    got = 1'b0;
    o = '0;

    if (set_mode[0] == 1'b0) begin
      // zero insertion: scatter to the scaled position
      tr = pix_row * ys;
      tc = pix_col * xs;
      if (tr < oh && tc < ow) begin
        span_r = lesser(ih, (oh + ys - 1) / ys);
        span_c = lesser(iw, (ow + xs - 1) / xs);
        o.row = tr[11:0];
        o.col = tc[11:0];
        o.sum = p[23:0];
        o.last = pix_row >= span_r - 1 && pix_col >= span_c - 1;
        got = 1'b1;
      end
    end else begin
      // block sum: running row sum, then column partial per block column
      h_close = in_blk_col >= xs - 1 || row_end;
      v_close = in_blk_row >= ys - 1 || frame_end;
      if (tgt_blk_row < oh && tgt_blk_col < ow && tgt_blk_col < LINE_DEPTH) begin
        part = clip24((in_blk_col == 0 ? 0 : run_sum) + p);
        run_sum = part;
        if (h_close) begin
          total = clip24((in_blk_row == 0 ? 0 : col_sum[tgt_blk_col]) + part);
          if (v_close) begin
            span_r = lesser(oh, (ih + ys - 1) / ys);
            span_c = lesser(ow, (iw + xs - 1) / xs);
            o.row = tgt_blk_row[11:0];
            o.col = tgt_blk_col[11:0];
            o.sum = total[23:0];
            o.last = tgt_blk_row >= span_r - 1 && tgt_blk_col >= span_c - 1;
            got = 1'b1;
          end else begin
            col_sum[tgt_blk_col] = total;
          end
        end
      end
    end

    // raster counters
    if (row_end) begin
      pix_col = 0;
      in_blk_col = 0;
      tgt_blk_col = 0;
      if (frame_end) begin
        pix_row = 0;
        in_blk_row = 0;
        tgt_blk_row = 0;
      end else begin
        pix_row++;
        if (in_blk_row >= ys - 1) begin
          in_blk_row = 0;
          tgt_blk_row++;
        end else begin
          in_blk_row++;
        end
      end
    end else begin
      pix_col++;
      if (in_blk_col >= xs - 1) begin
        in_blk_col = 0;
        tgt_blk_col++;
      end else begin
        in_blk_col++;
      end
    end
    return got;
  endfunction

  // pixels still needed to close the current frame
  function automatic int unsigned frame_left();
    int unsigned iw, ih, row_left;
    iw = eff_size(set_in_w);
    ih = eff_size(set_in_h);
    row_left = (pix_col >= iw - 1) ? 1 : iw - pix_col;
    return (pix_row >= ih - 1) ? row_left : row_left + (ih - 1 - pix_row) * iw;
  endfunction

  // ------------------------------------------------------------------ checker
  task automatic flag_fault(input string what, input out_pixel_t want, input out_pixel_t seen);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%s: want row %0d col %0d sum %0d last %0d, got row %0d col %0d sum %0d last %0d",
               what, want.row, want.col, $signed(want.sum), want.last,
               seen.row, seen.col, $signed(seen.sum), seen.last);
    end
  endtask

  // result check, then prediction for the pixel taken at this edge
  always @(posedge clk) begin : check_and_predict
    out_pixel_t seen;
    out_pixel_t want;
    out_pixel_t guess;
    bit         got;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen = {m_axis_tdata[11:0], m_axis_tdata[23:12], m_axis_tdata[47:24], m_axis_tlast};
        if (pending_writes.size() == 0) begin
          flag_fault("result with none due", '0, seen);
        end else begin
          want = pending_writes.pop_front();
          if (seen.row !== want.row || seen.col !== want.col ||
              seen.sum !== want.sum || seen.last !== want.last) begin
            flag_fault("result mismatch", want, seen);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        got = resize_step(s_axis_tdata, guess);
        if (pix_known) begin
          pending_writes.insert(pending_writes.size(), pix_want);
        end else if (got) begin
          pending_writes.insert(pending_writes.size(), guess);
        end
      end
    end
  end

  // sink back-pressure
  always @(posedge clk) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 26);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_additive_resize_core: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  // one pixel transaction, sometimes with a random gap ahead of it
  task automatic push_pixel(input logic [15:0] v, input bit known, input out_pixel_t want);
    bit took;
    if (!calm && $urandom_range(0, 99) < 18) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= v;
    pix_known <= known;
    pix_want <= want;
    do begin
      @(negedge clk);
      took = s_axis_tready;
      @(posedge clk);
    end while (!took);
  endtask

  task automatic push_random();
    logic [15:0] v;
    case ($urandom_range(0, 7))
      0: v = 16'h7FFF;
      1: v = 16'h8000;
      default: v = 16'($urandom);
    endcase
    push_pixel(v, 1'b0, '0);
    random_sent++;
  endtask

  // drain: no pixel offered, every write seen, pipeline empty
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write_reg(input logic [ars_pkg::IDX_W-1:0] idx, input logic [12:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      ars_pkg::REG_MODE:       set_mode = {12'd0, val[0]};
      ars_pkg::REG_IN_WIDTH:   set_in_w = val;
      ars_pkg::REG_IN_HEIGHT:  set_in_h = val;
      ars_pkg::REG_OUT_WIDTH:  set_out_w = val;
      ars_pkg::REG_OUT_HEIGHT: set_out_h = val;
      ars_pkg::REG_X_SCALE:    set_xs = {8'd0, val[4:0]};
      ars_pkg::REG_Y_SCALE:    set_ys = {8'd0, val[4:0]};
      default: ;
    endcase
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic frame_cfg(input logic [12:0] m, iw, ih, ow, oh, xs, ys);
    wait_idle();
    cfg_write_reg(ars_pkg::REG_MODE, m);
    cfg_write_reg(ars_pkg::REG_IN_WIDTH, iw);
    cfg_write_reg(ars_pkg::REG_IN_HEIGHT, ih);
    cfg_write_reg(ars_pkg::REG_OUT_WIDTH, ow);
    cfg_write_reg(ars_pkg::REG_OUT_HEIGHT, oh);
    cfg_write_reg(ars_pkg::REG_X_SCALE, xs);
    cfg_write_reg(ars_pkg::REG_Y_SCALE, ys);
  endtask

  task automatic finish_frame();
    int unsigned n;
    wait_idle();
    n = frame_left();
    repeat (n) push_random();
  endtask

  function automatic int unsigned pick_ratio();
    case ($urandom_range(0, 7))
      0: return 16;
      1: return $urandom_range(5, 15);
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  // register word for a ratio: sometimes out of range or with junk upper bits
  function automatic logic [12:0] ratio_word(input int unsigned s);
    logic [7:0] junk;
    junk = 8'($urandom);
    case ($urandom_range(0, 5))
      0: begin
        if (s == 1) return 13'd0;
        if (s == 16) return 13'($urandom_range(17, 31));
        return 13'(s);
      end
      1: return {junk, 5'(s)};
      default: return 13'(s);
    endcase
  endfunction

  function automatic logic [12:0] size_word(input int unsigned v);
    if (v == 1 && $urandom_range(0, 3) == 0) return 13'd0;
    return 13'(v);
  endfunction

  // random but consistent frame setup, mostly matched sizes
  task automatic pick_config(input bit up_only);
    int unsigned m, xs, ys, iw, ih, ow, oh;
    logic [12:0] mode_word;
    m = up_only ? 0 : $urandom_range(0, 1);
    xs = pick_ratio();
    ys = pick_ratio();
    iw = $urandom_range(1, 20);
    ih = $urandom_range(1, 10);
    if (m == 1) begin
      ow = (iw + xs - 1) / xs;
      oh = (ih + ys - 1) / ys;
    end else begin
      ow = (iw - 1) * xs + 1 + $urandom_range(0, xs - 1);
      oh = (ih - 1) * ys + 1 + $urandom_range(0, ys - 1);
    end
    case ($urandom_range(0, 9))
      0: ow = $urandom_range(1, ow);
      1: oh = $urandom_range(1, oh);
      2: ow = $urandom_range(4097, 8191);
      3: oh = $urandom_range(4097, 8191);
      4: ow = ow + $urandom_range(1, 5);
      default: ;
    endcase
    mode_word = 13'(m);
    if ($urandom_range(0, 7) == 0) mode_word = {12'($urandom), 1'(m)};
    frame_cfg(mode_word, size_word(iw), size_word(ih), size_word(ow), size_word(oh),
              ratio_word(xs), ratio_word(ys));
  endtask

  // directed table rows
  function automatic void table_add(input dir_step_t s);
    directed_steps.insert(directed_steps.size(), s);
  endfunction

  function automatic dir_step_t step_cfg(input logic [ars_pkg::IDX_W-1:0] idx,
                                         input logic [12:0] val);
    dir_step_t s;
    s = '{1'b1, idx, {3'd0, val}, 1'b0, '0};
    return s;
  endfunction

  function automatic dir_step_t step_pix(input logic [15:0] v);
    dir_step_t s;
    s = '{1'b0, '0, v, 1'b0, '0};
    return s;
  endfunction

  function automatic dir_step_t step_known(input logic [15:0] v, input logic [11:0] r,
                                           input logic [11:0] c, input logic [23:0] sum,
                                           input logic last);
    dir_step_t s;
    s = '{1'b0, '0, v, 1'b1, '{r, c, sum, last}};
    return s;
  endfunction

  initial begin
    int unsigned frame;
    int unsigned k;

    // after reset: 1x1 upsample, every pixel lands on (0,0) and ends the frame
    table_add(step_known(16'h7FFF, 12'd0, 12'd0, 24'h007FFF, 1'b1));
    table_add(step_known(16'h8000, 12'd0, 12'd0, 24'hFF8000, 1'b1));
    table_add(step_known(16'h0000, 12'd0, 12'd0, 24'h000000, 1'b1));
    table_add(step_known(16'hFFFF, 12'd0, 12'd0, 24'hFFFFFF, 1'b1));
    table_add(step_known(16'h5555, 12'd0, 12'd0, 24'h005555, 1'b1));
    table_add(step_known(16'hAAAA, 12'd0, 12'd0, 24'hFFAAAA, 1'b1));
    // 3x3 into 2x2 blocks: ragged right column and bottom row
    table_add(step_cfg(ars_pkg::REG_MODE, 13'd1));
    table_add(step_cfg(ars_pkg::REG_IN_WIDTH, 13'd3));
    table_add(step_cfg(ars_pkg::REG_IN_HEIGHT, 13'd3));
    table_add(step_cfg(ars_pkg::REG_OUT_WIDTH, 13'd2));
    table_add(step_cfg(ars_pkg::REG_OUT_HEIGHT, 13'd2));
    table_add(step_cfg(ars_pkg::REG_X_SCALE, 13'd2));
    table_add(step_cfg(ars_pkg::REG_Y_SCALE, 13'd2));
    table_add(step_pix(16'h7FFF));
    table_add(step_pix(16'h7FFF));
    table_add(step_pix(16'h8000));
    table_add(step_pix(16'h1234));
    table_add(step_pix(16'h7FFF));
    table_add(step_pix(16'h0001));
    table_add(step_pix(16'h8000));
    table_add(step_pix(16'hFFFF));
    table_add(step_pix(16'h4000));
    // 2x2 upsampled into 3x2: second row falls outside the output
    table_add(step_cfg(ars_pkg::REG_MODE, 13'd0));
    table_add(step_cfg(ars_pkg::REG_IN_WIDTH, 13'd2));
    table_add(step_cfg(ars_pkg::REG_IN_HEIGHT, 13'd2));
    table_add(step_cfg(ars_pkg::REG_OUT_WIDTH, 13'd3));
    table_add(step_pix(16'h2222));
    table_add(step_pix(16'hC000));
    table_add(step_pix(16'h7FFF));
    table_add(step_pix(16'h8000));
    // out-of-range registers: zero sizes act as one, big values clamp
    table_add(step_cfg(ars_pkg::REG_MODE, 13'd1));
    table_add(step_cfg(ars_pkg::REG_IN_WIDTH, 13'd0));
    table_add(step_cfg(ars_pkg::REG_OUT_WIDTH, 13'd8191));
    table_add(step_cfg(ars_pkg::REG_OUT_HEIGHT, 13'd0));
    table_add(step_cfg(ars_pkg::REG_X_SCALE, 13'd0));
    table_add(step_cfg(ars_pkg::REG_Y_SCALE, 13'd31));
    table_add(step_pix(16'h7FFF));
    table_add(step_known(16'h7FFF, 12'd0, 12'd0, 24'h00FFFE, 1'b1));

    // reset
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed part
    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_cfg) begin
        wait_idle();
        cfg_write_reg(directed_steps[i].idx, directed_steps[i].val[12:0]);
      end else begin
        push_pixel(directed_steps[i].val, directed_steps[i].known, directed_steps[i].want);
      end
    end

    // random frames; one stretch runs with both sides always ready
    while (random_sent < RANDOM_ITEMS) begin
      calm = random_sent >= 500 && random_sent < 850;
      pick_config(1'b0);
      frame = eff_size(set_in_w) * eff_size(set_in_h);
      if (set_mode[0] == 1'b0 && frame > 1 && $urandom_range(0, 4) == 0) begin
        // reconfigure part way through an upsample frame
        k = $urandom_range(1, frame - 1);
        repeat (k) push_random();
        pick_config(1'b1);
        finish_frame();
      end else begin
        repeat ($urandom_range(1, 2)) finish_frame();
      end
    end
    calm = 1'b0;

    // large targets: widest target row, tallest target column
    frame_cfg(13'd0, 13'd256, 13'd1, 13'd8191, 13'd1, 13'd16, 13'd1);
    finish_frame();
    frame_cfg(13'd0, 13'd1, 13'd256, 13'd1, 13'd4096, 13'd1, 13'd16);
    finish_frame();

    // drain and report
    wait_idle();
    repeat (8) @(posedge clk);
    if (fault_count == 0) begin
      $display("tb_additive_resize_core: clean");
    end else begin
      $display("tb_additive_resize_core: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/ars_pkg.sv
hdl/ars_ram.sv
hdl/additive_resize_core.sv
tb/sv/tb_additive_resize_core.sv
